// ===== src/trd_pkg.sv =====
// shared types and constants for the rle pixel decoder
// no dependencies; used by every module of the decoder
`timescale 1ns / 1ps

package trd_pkg;

    // widths of the stream, pixel and counter
    localparam int COUNT_BITS  = 25;
    localparam int PIXEL_BITS  = 32;
    localparam int BYTE_BITS   = 8;
    localparam int REP_BITS    = 8;
    localparam int BPP_BITS    = 3;
    localparam int SLOT_BITS   = 2;
    localparam int ADDR_BITS   = 3;
    localparam int DATA_BITS   = 32;

    // register reset values
    localparam logic [BPP_BITS-1:0]   BPP_RESET   = BPP_BITS'(4);
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(1);

    // packet header split: below RUN_FLAG is raw, run length is header - RUN_BIAS
    localparam logic [BYTE_BITS-1:0] RUN_FLAG = BYTE_BITS'(128);
    localparam logic [BYTE_BITS-1:0] RUN_BIAS = BYTE_BITS'(127);

    // register indexes
    localparam logic REG_BPP   = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_RAW    = 2'd1,
        PH_RUN    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DONE     = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [BPP_BITS-1:0]   bytes_per_pixel;
        logic [COUNT_BITS-1:0] pixel_count;
    } cfg_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_value;
        logic [REP_BITS-1:0]   repeat_count;
        status_t               status;
    } result_t;

endpackage

// ===== src/trd_apb_regs.sv =====
// configuration registers behind an apb-style port
// depends on trd_pkg
`timescale 1ns / 1ps

module trd_apb_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [trd_pkg::ADDR_BITS-1:0] paddr,
    input  logic [trd_pkg::DATA_BITS-1:0] pwdata,
    output logic [trd_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    output trd_pkg::cfg_t                 cfg
);

    logic [trd_pkg::BPP_BITS-1:0]   bpp_reg;
    logic [trd_pkg::COUNT_BITS-1:0] count_reg;
    logic                           wr_en;
    logic                           reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg   <= trd_pkg::BPP_RESET;
            count_reg <= trd_pkg::COUNT_RESET;
        end
        else if (wr_en)
        begin
            if (reg_sel == trd_pkg::REG_BPP)
            begin
                bpp_reg <= pwdata[trd_pkg::BPP_BITS-1:0];
            end
            else
            begin
                count_reg <= pwdata[trd_pkg::COUNT_BITS-1:0];
            end
        end
    end

    // read mux
    always_comb
    begin
        if (reg_sel == trd_pkg::REG_BPP)
        begin
            prdata = trd_pkg::DATA_BITS'(bpp_reg);
        end
        else
        begin
            prdata = trd_pkg::DATA_BITS'(count_reg);
        end
    end

    assign cfg.bytes_per_pixel = bpp_reg;
    assign cfg.pixel_count     = count_reg;

endmodule

// ===== src/trd_core.sv =====
// byte input register and packet decoder state
// depends on trd_pkg
`timescale 1ns / 1ps

module trd_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [trd_pkg::BYTE_BITS-1:0] data_byte,
    input  trd_pkg::cfg_t                 cfg,
    input  logic                          res_ready,
    output logic                          res_valid,
    output trd_pkg::result_t              res
);

    // input register
    logic                               in_valid_reg;
    logic                               in_valid_next;
    logic [trd_pkg::BYTE_BITS-1:0]      data_reg;

    // decoder state
    trd_pkg::phase_t                    phase_reg;
    trd_pkg::phase_t                    phase_next;
    logic [trd_pkg::REP_BITS-1:0]       left_reg;
    logic [trd_pkg::REP_BITS-1:0]       left_next;
    logic [trd_pkg::SLOT_BITS-1:0]      slot_reg;
    logic [trd_pkg::SLOT_BITS-1:0]      slot_next;
    logic [trd_pkg::PIXEL_BITS-1:0]     build_reg;
    logic [trd_pkg::PIXEL_BITS-1:0]     build_next;
    logic [trd_pkg::COUNT_BITS-1:0]     done_reg;
    logic [trd_pkg::COUNT_BITS-1:0]     done_next;

    // datapath
    logic                               in_packet;
    logic                               is_raw;
    logic [trd_pkg::BPP_BITS-1:0]       eff_bpp;
    logic [trd_pkg::BPP_BITS-1:0]       slot_plus;
    logic                               pixel_end;
    logic                               has_result;
    logic                               proc;
    logic [trd_pkg::PIXEL_BITS-1:0]     build_or;
    logic [trd_pkg::REP_BITS-1:0]       rep;
    logic [trd_pkg::REP_BITS-1:0]       left_dec;
    logic                               packet_end;
    logic [trd_pkg::COUNT_BITS:0]       total;
    logic [trd_pkg::COUNT_BITS:0]       limit;
    logic                               over;
    logic                               complete;
    trd_pkg::status_t                   status;

    // a byte moves on unless it finishes a pixel and the result slot is full and stalled
    assign proc     = in_valid_reg && (!has_result || res_ready);
    assign in_stall = in_valid_reg && !proc;

    always_comb
    begin
        in_valid_next = in_stall ? in_valid_reg : in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            data_reg <= data_byte;
        end
    end

    // effective bytes per pixel: zero acts as one, above four acts as four
    always_comb
    begin
        if (cfg.bytes_per_pixel == '0)
        begin
            eff_bpp = trd_pkg::BPP_BITS'(1);
        end
        else if (cfg.bytes_per_pixel > trd_pkg::BPP_BITS'(4))
        begin
            eff_bpp = trd_pkg::BPP_BITS'(4);
        end
        else
        begin
            eff_bpp = cfg.bytes_per_pixel;
        end
    end

    // pixel assembly and packet bookkeeping
    assign in_packet  = (phase_reg == trd_pkg::PH_RAW) || (phase_reg == trd_pkg::PH_RUN);
    assign is_raw     = (phase_reg == trd_pkg::PH_RAW);
    assign slot_plus  = trd_pkg::BPP_BITS'(slot_reg) + trd_pkg::BPP_BITS'(1);
    assign pixel_end  = (slot_plus >= eff_bpp);
    assign has_result = in_packet && pixel_end;
    assign build_or   = build_reg
                      | (trd_pkg::PIXEL_BITS'(data_reg) << {slot_reg, 3'b000});
    assign left_dec   = left_reg - trd_pkg::REP_BITS'(1);
    assign rep        = is_raw ? trd_pkg::REP_BITS'(1) : left_reg;
    assign packet_end = is_raw ? (left_dec == '0) : 1'b1;

    // pixel count check
    assign total    = {1'b0, done_reg} + (trd_pkg::COUNT_BITS + 1)'(rep);
    assign limit    = {1'b0, cfg.pixel_count};
    assign over     = (total > limit);
    assign complete = packet_end && (total == limit);

    always_comb
    begin
        if (over)
        begin
            status = trd_pkg::ST_OVERFLOW;
        end
        else if (complete)
        begin
            status = trd_pkg::ST_DONE;
        end
        else
        begin
            status = trd_pkg::ST_OK;
        end
    end

    // next decoder state
    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        slot_next  = slot_reg;
        build_next = build_reg;
        done_next  = done_reg;
        if (proc)
        begin
            if (!in_packet)
            begin
                if (data_reg < trd_pkg::RUN_FLAG)
                begin
                    phase_next = trd_pkg::PH_RAW;
                    left_next  = data_reg + trd_pkg::REP_BITS'(1);
                end
                else
                begin
                    phase_next = trd_pkg::PH_RUN;
                    left_next  = data_reg - trd_pkg::RUN_BIAS;
                end
                slot_next  = '0;
                build_next = '0;
            end
            else if (!pixel_end)
            begin
                build_next = build_or;
                slot_next  = slot_reg + trd_pkg::SLOT_BITS'(1);
            end
            else
            begin
                slot_next  = '0;
                build_next = '0;
                left_next  = is_raw ? left_dec : '0;
                if (over || complete)
                begin
                    phase_next = trd_pkg::PH_HEADER;
                    left_next  = '0;
                    done_next  = '0;
                end
                else
                begin
                    done_next = total[trd_pkg::COUNT_BITS-1:0];
                    if (packet_end)
                    begin
                        phase_next = trd_pkg::PH_HEADER;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= trd_pkg::PH_HEADER;
            left_reg  <= '0;
            slot_reg  <= '0;
            build_reg <= '0;
            done_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            slot_reg  <= slot_next;
            build_reg <= build_next;
            done_reg  <= done_next;
        end
    end

    // result toward the output register
    assign res_valid        = proc && has_result;
    assign res.pixel_value  = build_or;
    assign res.repeat_count = rep;
    assign res.status       = status;

endmodule

// ===== src/trd_out_stage.sv =====
// result register with valid/stall handshake
// depends on trd_pkg
`timescale 1ns / 1ps

module trd_out_stage
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           res_valid,
    input  trd_pkg::result_t               res,
    output logic                           res_ready,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [trd_pkg::PIXEL_BITS-1:0] pixel_value,
    output logic [trd_pkg::REP_BITS-1:0]   repeat_count,
    output logic [1:0]                     status
);

    logic             out_valid_reg;
    logic             out_valid_next;
    trd_pkg::result_t res_reg;

    // slot is free when empty or its request leaves this cycle
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_value  = res_reg.pixel_value;
    assign repeat_count = res_reg.repeat_count;
    assign status       = res_reg.status;

endmodule

// ===== src/tga_rle_pixel_decoder.sv =====
// path: a byte that finishes a pixel goes from the input register through the decode logic
// into the result register, which drives the ports; a full, stalled result register holds it back
// throughput: one byte per cycle, set by the single decode stage between the input
// register and the result register; a full, stalled result register holds back input
// reset: rst_n clears the decoder to await a packet header, empties both registers,
// and sets bytes_per_pixel to 4 and pixel_count to 1
`timescale 1ns / 1ps

module tga_rle_pixel_decoder
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [trd_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [trd_pkg::DATA_BITS-1:0]  pwdata,
    output logic [trd_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [trd_pkg::BYTE_BITS-1:0]  data_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [trd_pkg::PIXEL_BITS-1:0] pixel_value,
    output logic [trd_pkg::REP_BITS-1:0]   repeat_count,
    output logic [1:0]                     status
);

    trd_pkg::cfg_t    cfg;
    trd_pkg::result_t res;
    logic             res_valid;
    logic             res_ready;

    // configuration registers
    trd_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // packet decoder
    trd_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .cfg       (cfg),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register
    trd_out_stage u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_valid),
        .res          (res),
        .res_ready    (res_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_value  (pixel_value),
        .repeat_count (repeat_count),
        .status       (status)
    );

endmodule

// ===== src/trd_checker.sv =====
// port-level checks for the rle pixel decoder, bound to the top level
// depends on trd_pkg and tga_rle_pixel_decoder
`timescale 1ns / 1ps

module trd_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [trd_pkg::PIXEL_BITS-1:0] pixel_value,
    input logic [trd_pkg::REP_BITS-1:0]   repeat_count,
    input logic [1:0]                     status
);

    // a stalled result request holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_value)
            && $stable(repeat_count) && $stable(status))
        else $error("result changed while stalled");

    // input backs up only behind a full, stalled result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // repeat count is one to the longest run
    a_rep_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> repeat_count != '0 && repeat_count <= trd_pkg::RUN_FLAG)
        else $error("repeat count out of range");

    // status is one of the three codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == trd_pkg::ST_OK || status == trd_pkg::ST_DONE
            || status == trd_pkg::ST_OVERFLOW)
        else $error("bad status code");

endmodule

bind tga_rle_pixel_decoder trd_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_value  (pixel_value),
    .repeat_count (repeat_count),
    .status       (status)
);

// ===== dv/testbench.sv =====
// testbench for tga_rle_pixel_decoder: run-length packet bytes in, pixel results out
// depends on src/trd_pkg.sv and src/tga_rle_pixel_decoder.sv; a built-in decoder predicts results
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_PERIOD    = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BYTES  = 1800;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [trd_pkg::ADDR_BITS-1:0]  paddr;
    logic [trd_pkg::DATA_BITS-1:0]  pwdata;
    logic [trd_pkg::DATA_BITS-1:0]  prdata;
    logic                           pready;
    logic                           in_valid;
    logic                           in_stall;
    logic [trd_pkg::BYTE_BITS-1:0]  data_byte;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [trd_pkg::PIXEL_BITS-1:0] pixel_value;
    logic [trd_pkg::REP_BITS-1:0]   repeat_count;
    logic [1:0]                     status;

    tga_rle_pixel_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_value  (pixel_value),
        .repeat_count (repeat_count),
        .status       (status)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // register copies and decoder state mirrored by the predictor
    logic [trd_pkg::BPP_BITS-1:0]   cfg_bpp;
    logic [trd_pkg::COUNT_BITS-1:0] cfg_count;
    trd_pkg::phase_t                dec_phase;
    logic [7:0]                     dec_left;
    logic [trd_pkg::SLOT_BITS-1:0]  dec_slot;
    logic [trd_pkg::PIXEL_BITS-1:0] dec_build;
    logic [trd_pkg::COUNT_BITS-1:0] dec_done;

    trd_pkg::result_t expected_pixels[$];
    int      error_count = 0;
    int      bytes_sent  = 0;
    int      burst_left  = 0;
    int      stall_mode  = 0;
    int      stall_span  = 0;

    // bytes that make up one pixel; out-of-range sizes clamp to 1 or 4
    function automatic int pixel_bytes();
        if (cfg_bpp == 0)
        begin
            return 1;
        end
        if (cfg_bpp > 4)
        begin
            return 4;
        end
        return int'(cfg_bpp);
    endfunction

    // advance the mirrored decoder by one stream byte, queue any pixel it finishes
    function automatic void decode_byte(input logic [trd_pkg::BYTE_BITS-1:0] b);
        logic [trd_pkg::PIXEL_BITS-1:0] pix;
        logic [7:0]                     rep;
        logic                           packet_end;
        logic [trd_pkg::COUNT_BITS:0]   total;
        trd_pkg::result_t               r;
        if (dec_phase == trd_pkg::PH_HEADER)
        begin
            if (b < trd_pkg::RUN_FLAG)
            begin
                dec_phase = trd_pkg::PH_RAW;
                dec_left  = b + 8'd1;
            end
            else
            begin
                dec_phase = trd_pkg::PH_RUN;
                dec_left  = b - trd_pkg::RUN_BIAS;
            end
            dec_slot  = '0;
            dec_build = '0;
            return;
        end
        dec_build = dec_build | (trd_pkg::PIXEL_BITS'(b) << (8 * dec_slot));
        if (int'(dec_slot) + 1 < pixel_bytes())
        begin
            dec_slot = dec_slot + 1'b1;
            return;
        end
        pix = dec_build;
        if (dec_phase == trd_pkg::PH_RAW)
        begin
            rep        = 8'd1;
            dec_left   = dec_left - 8'd1;
            packet_end = (dec_left == 0);
        end
        else
        begin
            rep        = dec_left;
            dec_left   = '0;
            packet_end = 1'b1;
        end
        dec_slot  = '0;
        dec_build = '0;
        total     = {1'b0, dec_done} + (trd_pkg::COUNT_BITS + 1)'(rep);
        r.pixel_value  = pix;
        r.repeat_count = rep;
        if (total > {1'b0, cfg_count})
        begin
            r.status  = trd_pkg::ST_OVERFLOW;
            dec_phase = trd_pkg::PH_HEADER;
            dec_left  = '0;
            dec_done  = '0;
        end
        else if (packet_end && total == {1'b0, cfg_count})
        begin
            r.status  = trd_pkg::ST_DONE;
            dec_phase = trd_pkg::PH_HEADER;
            dec_left  = '0;
            dec_done  = '0;
        end
        else
        begin
            r.status = trd_pkg::ST_OK;
            dec_done = total[trd_pkg::COUNT_BITS-1:0];
            if (packet_end)
            begin
                dec_phase = trd_pkg::PH_HEADER;
            end
        end
        expected_pixels.push_back(r);
    endfunction

    // watch both channels: predict on each accepted byte, check each accepted pixel
    always @(posedge clk)
    begin : channel_monitor
        trd_pkg::result_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            decode_byte(data_byte);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected pixel: value %08h repeat %0d status %0d",
                       pixel_value, repeat_count, status);
                error_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (pixel_value !== want.pixel_value)
                begin
                    $error("pixel_value: expected %08h, got %08h", want.pixel_value, pixel_value);
                    error_count++;
                end
                if (repeat_count !== want.repeat_count)
                begin
                    $error("repeat_count: expected %0d, got %0d", want.repeat_count,
                           repeat_count);
                    error_count++;
                end
                if (status !== 2'(want.status))
                begin
                    $error("status: expected %0d, got %0d", 2'(want.status), status);
                    error_count++;
                end
            end
        end
    end

    // receiver stall pattern: free-running, random, mostly stalled, long stall blocks
    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(16, 160);
        end
        else
        begin
            stall_span--;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            2: out_stall <= (stall_span % 4 != 0);
            default: out_stall <= stall_span[4];
        endcase
    end

    // run limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    // one byte request; called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [trd_pkg::BYTE_BITS-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 32);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_pixel();
        repeat (pixel_bytes()) send_byte(trd_pkg::BYTE_BITS'($urandom_range(0, 255)));
    endtask

    // drop valid and hold off until every pixel is out and the pipeline has drained
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // register write then read-back, both two-phase transfers
    task automatic write_reg(input logic idx, input logic [trd_pkg::DATA_BITS-1:0] value);
        logic [trd_pkg::DATA_BITS-1:0] want;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= trd_pkg::ADDR_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == trd_pkg::REG_BPP)
        begin
            cfg_bpp = value[trd_pkg::BPP_BITS-1:0];
            want    = trd_pkg::DATA_BITS'(cfg_bpp);
        end
        else
        begin
            cfg_count = value[trd_pkg::COUNT_BITS-1:0];
            want      = trd_pkg::DATA_BITS'(cfg_count);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
        begin
            $error("prdata: expected %08h, got %08h", want, prdata);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // every register bit both ways, read back each time
    task automatic test_registers();
        write_reg(trd_pkg::REG_BPP, 32'hFFFF_FFFF);
        write_reg(trd_pkg::REG_COUNT, 32'hFFFF_FFFF);
        write_reg(trd_pkg::REG_BPP, 32'h0000_0000);
        write_reg(trd_pkg::REG_COUNT, 32'h0000_0000);
    endtask

    // raw packet of three gray pixels that completes the image
    task automatic test_raw_packets();
        write_reg(trd_pkg::REG_BPP, 32'd1);
        write_reg(trd_pkg::REG_COUNT, 32'd3);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        wait_idle();
    endtask

    // longest run, then a single-pixel run that completes the image
    task automatic test_run_packets();
        write_reg(trd_pkg::REG_BPP, 32'd3);
        write_reg(trd_pkg::REG_COUNT, 32'd129);
        send_byte(8'hFF);
        send_pixel();
        send_byte(8'h80);
        send_pixel();
        wait_idle();
    endtask

    // zero pixel count, then a raw packet that passes the count mid-packet
    task automatic test_overflow();
        write_reg(trd_pkg::REG_BPP, 32'd5);
        write_reg(trd_pkg::REG_COUNT, 32'd0);
        send_byte(8'h00);
        send_pixel();
        wait_idle();
        write_reg(trd_pkg::REG_BPP, 32'd0);
        write_reg(trd_pkg::REG_COUNT, 32'd2);
        send_byte(8'h04);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        wait_idle();
    endtask

    // pixel size shrinks while a pixel is half built
    task automatic test_bpp_change();
        write_reg(trd_pkg::REG_BPP, 32'd4);
        write_reg(trd_pkg::REG_COUNT, 32'h0100_0000);
        send_byte(8'h00);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        wait_idle();
        write_reg(trd_pkg::REG_BPP, 32'd2);
        send_byte(8'hC4);
        wait_idle();
    endtask

    // well-formed images with random packets and sizes, some overshoot and some noise
    task automatic test_random_images();
        int start;
        int left;
        int n;
        int pick;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                wait_idle();
                write_reg(trd_pkg::REG_BPP, ($urandom & ~32'h7) | $urandom_range(0, 7));
                pick = $urandom_range(0, 19);
                if (pick == 0)
                begin
                    n = 0;
                end
                else if (pick == 1)
                begin
                    n = 32'h01FF_FFFF;
                end
                else if (pick == 2)
                begin
                    n = 32'h0100_0000;
                end
                else
                begin
                    n = $urandom_range(1, 24);
                end
                write_reg(trd_pkg::REG_COUNT, ($urandom & ~32'h01FF_FFFF) | n);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(trd_pkg::BYTE_BITS'($urandom_range(0, 255)));
            end
            else
            begin
                if (cfg_count == 0)
                begin
                    left = 1;
                end
                else if (cfg_count > 48)
                begin
                    left = $urandom_range(1, 48);
                end
                else
                begin
                    left = int'(cfg_count);
                end
                while (left > 0)
                begin
                    n = $urandom_range(1, (left > 128) ? 128 : left);
                    if ($urandom_range(0, 9) == 0)
                    begin
                        n = $urandom_range(1, 128);
                    end
                    if ($urandom_range(0, 1) == 0)
                    begin
                        send_byte(trd_pkg::BYTE_BITS'(n - 1));
                        repeat (n) send_pixel();
                    end
                    else
                    begin
                        send_byte(trd_pkg::BYTE_BITS'(n + 127));
                        send_pixel();
                    end
                    left -= n;
                end
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        data_byte = '0;
        cfg_bpp   = trd_pkg::BPP_RESET;
        cfg_count = trd_pkg::COUNT_RESET;
        dec_phase = trd_pkg::PH_HEADER;
        dec_left  = '0;
        dec_slot  = '0;
        dec_build = '0;
        dec_done  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_registers();
        test_raw_packets();
        test_run_packets();
        test_overflow();
        test_bpp_change();
        test_random_images();

        // drain and let the pipeline settle
        wait_idle();
        repeat (8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
